// ===== hdl/lru_page_replacement_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRUPR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrupr check failed");

// The consequent must hold in the cycle after the antecedent.
`define LRUPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrupr check failed");

`endif

// ===== hdl/lrupr_pkg.sv =====
package lrupr_pkg;

  localparam int PROCESSES = 16;
  localparam int PAGES     = 32;
  localparam int PAGE_SIZE = 128;  // power of two

  localparam int PROC_W     = 4;
  localparam int PC_W       = 12;
  localparam int RES_W      = 32;
  localparam int OUT_PAGE_W = 5;
  localparam int STAMP_W    = 32;

  localparam int PAGE_W     = $clog2(PAGES);
  localparam int PAGE_SHIFT = $clog2(PAGE_SIZE);
  localparam int MEM_DEPTH  = PROCESSES * PAGES;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);

  localparam logic [STAMP_W-1:0] NOW_MAX = '1;

  // Control from the sequencer to the victim search unit.
  typedef struct packed {
    logic               clear;
    logic [STAMP_W-1:0] start_stamp;
    logic               sample;
    logic [PAGE_W-1:0]  idx;
    logic               res;
  } lrupr_scan_t;

endpackage

// ===== hdl/lru_page_replacement.sv =====
// A new input item is taken only after the previous result has been loaded
// into the output register. When the resident pages are scanned for a victim,
// the search reads the single read port of the stamp memory one page per cycle.
// Reset: synchronous, active high; afterward a clearing pass zeroes every
// entry of the stamp memory before the first item is taken.
module lru_page_replacement
  import lrupr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PROC_W-1:0]     process,
  input  logic                  active,
  input  logic [PC_W-1:0]       pc,
  input  logic [RES_W-1:0]      resident,
  input  logic                  frame_free,
  input  logic                  end_of_tick,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_PAGE_W-1:0] page,
  output logic                  pagein_request,
  output logic                  evict_valid,
  output logic [OUT_PAGE_W-1:0] evict_page
);

`include "lru_page_replacement_macros.svh"

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_LAST  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // The stamp memory holds the last tick at which each page of each process
  // was used. It has one write port and one registered read port.
  logic [STAMP_W-1:0] mem [MEM_DEPTH];
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [STAMP_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]  rd_addr;
  logic [STAMP_W-1:0] rd_data;

  logic [ADDR_W-1:0]  clr_addr;
  logic [STAMP_W-1:0] now;

  // Fields of the transaction in progress.
  logic [PROC_W-1:0]     proc_q;
  logic [RES_W-1:0]      res_q;
  logic [OUT_PAGE_W-1:0] page_q;
  logic                  req_q;

  logic [PAGE_W-1:0] scan_idx;
  logic              smp_valid;
  logic [PAGE_W-1:0] smp_idx;

  logic accept;
  logic proc_ok;
  logic [PC_W-1:0]   page_full;
  logic [PAGE_W-1:0] pg;
  logic page_ok;
  logic stamp;
  logic need_req;
  logic need_scan;
  logic out_free;

  lrupr_scan_t       scan_ctl;
  logic              found;
  logic [PAGE_W-1:0] victim;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Decode of the incoming transaction. The page size is a power of two,
  // so the page number is a plain shift of the program counter.
  always_comb begin
    proc_ok   = active && (32'(process) < 32'(PROCESSES));
    page_full = pc >> PAGE_SHIFT;
    pg        = page_full[PAGE_W-1:0];
    page_ok   = (32'(page_full) < 32'(PAGES));
    stamp     = proc_ok && page_ok;
    need_req  = stamp && !resident[pg];
    need_scan = need_req && !frame_free;
  end

  // Memory write source: the clearing pass after reset, otherwise the stamp
  // of the page used by an accepted transaction. The requested page is never
  // resident, so its new stamp cannot disturb the victim search.
  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = accept && stamp;
      mem_waddr = ADDR_W'(32'(process) * PAGES + 32'(pg));
      mem_wdata = now;
    end
    rd_addr = ADDR_W'(32'(proc_q) * PAGES + 32'(scan_idx));
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = need_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_idx == PAGE_W'(PAGES - 1)) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Sequencer, tick counter and scan address.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      now       <= STAMP_W'(1);
      scan_idx  <= '0;
      smp_valid <= 1'b0;
      smp_idx   <= '0;
    end else begin
      state     <= state_next;
      smp_valid <= (state == ST_SCAN);
      smp_idx   <= scan_idx;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (accept) begin
        scan_idx <= '0;
        // Time advances after the item that ends the tick and saturates.
        if (end_of_tick && (now != NOW_MAX)) begin
          now <= now + 1'b1;
        end
      end else if (state == ST_SCAN) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  // Captured transaction fields; an inactive process shows page zero.
  always_ff @(posedge clk) begin
    if (accept) begin
      proc_q <= process;
      res_q  <= resident;
      page_q <= proc_ok ? page_full[OUT_PAGE_W-1:0] : '0;
      req_q  <= need_req;
    end
  end

  always_comb begin
    scan_ctl.clear       = accept;
    scan_ctl.start_stamp = now;
    scan_ctl.sample      = smp_valid;
    scan_ctl.idx         = smp_idx;
    scan_ctl.res         = res_q[smp_idx];
  end

  lrupr_victim u_victim (
    .clk     (clk),
    .rst     (rst),
    .ctl     (scan_ctl),
    .rd_data (rd_data),
    .found   (found),
    .victim  (victim)
  );

  // Output register. It holds a finished result while the next transaction
  // is already being taken and worked on.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      page           <= page_q;
      pagein_request <= req_q;
      evict_valid    <= found;
      evict_page     <= OUT_PAGE_W'(victim);
    end
  end

  `LRUPR_ASSERT_NOW(a_evict_needs_req, out_valid && evict_valid, pagein_request)
  `LRUPR_ASSERT_NOW(a_no_victim_zero, out_valid && !evict_valid, evict_page == '0)
  `LRUPR_ASSERT_NEXT(a_one_at_a_time, accept, !in_ready)
  `LRUPR_ASSERT_NOW(a_tick_nonzero, 1'b1, now != '0)

endmodule

// ===== hdl/lrupr_victim.sv =====
module lrupr_victim
  import lrupr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  lrupr_scan_t        ctl,
  input  logic [STAMP_W-1:0] rd_data,
  output logic               found,
  output logic [PAGE_W-1:0]  victim
);

  logic [STAMP_W-1:0] best;

  // A resident page replaces the current choice only when strictly older,
  // so the lowest index wins on equal stamps.
  always_ff @(posedge clk) begin
    if (rst) begin
      found  <= 1'b0;
      victim <= '0;
      best   <= '0;
    end else if (ctl.clear) begin
      found  <= 1'b0;
      victim <= '0;
      best   <= ctl.start_stamp;
    end else if (ctl.sample && ctl.res && (rd_data < best)) begin
      found  <= 1'b1;
      victim <= ctl.idx;
      best   <= rd_data;
    end
  end

endmodule
